// ===== rtl/sad_pkg.sv =====
// Shared constants, register indexes and width helpers for the stereo average decimator.
`timescale 1ns / 1ps

package sad_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int MAX_RATIO_DEFAULT = 16;
  localparam int QUEUE_DEPTH       = 2;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MONO_MODE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DECIM_RATIO = 2'd2;

  // Width of a running sum that holds up to max_ratio samples.
  function automatic int sum_w(input int max_ratio);
    return SAMPLE_W + $clog2(max_ratio);
  endfunction

  // Width that holds a ratio or frame count from 0 to max_ratio.
  function automatic int ratio_w(input int max_ratio);
    return $clog2(max_ratio + 1);
  endfunction

  // Queue entry: left sum, right sum, ratio, mono flag, batch end (low bits first).
  function automatic int job_w(input int max_ratio);
    return 2 * sum_w(max_ratio) + ratio_w(max_ratio) + 2;
  endfunction

endpackage

// ===== rtl/stereo_average_decimator.sv =====
// Top level of the stereo boxcar averaging decimator.
`timescale 1ns / 1ps

// Usage:
// Stereo frames enter on the s_axis channel: left sample in tdata[15:0], right sample in
// tdata[31:16], and tlast as the batch-end flush hint. Averaged samples leave on m_axis:
// tdata is the 16-bit sample, tlast marks the final sample for a run, and tuser echoes the
// batch-end mark on that final sample. Registers are written on the cfg channel (index 0
// active, 1 mono_mode, 2 decim_ratio); cfg_ready is always high. The user is to write
// only while the block is idle, which the block does not enforce. While inactive,
// frames are taken and dropped. The front part takes one frame per cycle while its
// two-entry run queue has room, adding it into the running sums. A completed run is
// queued and the front keeps accepting. The back part works on one queued run with a
// shared restoring divider that yields one quotient bit per cycle: each output sample is
// loaded, divided over DIV_W quotient bits (21 with the default maximum ratio of 16) and
// registered, then shows until m_axis_tready. A stereo run gives two samples, left then
// right; mono gives one. If the receiver stalls, the sample holds on m_axis, the queue
// fills, and then s_axis_tready drops until a run is retired. Reset clears the sums, the
// frame count, the queue and the registers (inactive, stereo, ratio 1).

module stereo_average_decimator #(
  parameter int MAX_RATIO = sad_pkg::MAX_RATIO_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Frame requests.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // left_in, right_in
  input  logic                            s_axis_tlast,  // batch_end_in
  // Sample requests.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // sample_out
  output logic                            m_axis_tlast,  // last_of_run
  output logic                            m_axis_tuser,  // batch_end_out
  // Register writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sad_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int JOB_W = sad_pkg::job_w(MAX_RATIO);

  logic             job_push;
  logic [JOB_W-1:0] job_push_data;
  logic             job_full;
  logic             job_pop;
  logic             job_valid;
  logic [JOB_W-1:0] job_head;

  // Registers accept a write every cycle.
  assign cfg_ready = 1'b1;

  sad_front #(
    .MAX_RATIO(MAX_RATIO)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_valid  (s_axis_tvalid),
    .frame_ready  (s_axis_tready),
    .left_in      (s_axis_tdata[15:0]),
    .right_in     (s_axis_tdata[31:16]),
    .batch_end_in (s_axis_tlast),
    .job_push     (job_push),
    .job_data     (job_push_data),
    .job_full     (job_full)
  );

  // Completed runs wait here so the front can keep taking frames while the divider works.
  sad_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(sad_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_data  (job_push_data),
    .full       (job_full),
    .pop        (job_pop),
    .head_valid (job_valid),
    .head_data  (job_head)
  );

  sad_back #(
    .MAX_RATIO(MAX_RATIO)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job_data      (job_head),
    .job_pop       (job_pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .sample_out    (m_axis_tdata),
    .last_of_run   (m_axis_tlast),
    .batch_end_out (m_axis_tuser)
  );

endmodule

// ===== rtl/sad_front.sv =====
// Front part: configuration registers, frame accumulation and run completion.
`timescale 1ns / 1ps

module sad_front #(
  parameter int MAX_RATIO = sad_pkg::MAX_RATIO_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [sad_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sad_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               frame_valid,
  output logic                               frame_ready,
  input  logic signed [sad_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [sad_pkg::SAMPLE_W-1:0] right_in,
  input  logic                               batch_end_in,
  output logic                               job_push,
  output logic [sad_pkg::job_w(MAX_RATIO)-1:0] job_data,
  input  logic                               job_full
);

  localparam int SUM_W   = sad_pkg::sum_w(MAX_RATIO);
  localparam int RATIO_W = sad_pkg::ratio_w(MAX_RATIO);

  logic                      active;
  logic                      mono_mode;
  logic [sad_pkg::CFG_DATA_W-1:0] decim_ratio;

  logic signed [SUM_W-1:0]   left_sum;
  logic signed [SUM_W-1:0]   right_sum;
  logic [RATIO_W-1:0]        frames_gathered;

  logic [RATIO_W-1:0]        ratio_eff;
  logic signed [SUM_W-1:0]   left_sum_next;
  logic signed [SUM_W-1:0]   right_sum_next;
  logic [RATIO_W-1:0]        frames_gathered_next;
  logic                      accept;
  logic                      run_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      mono_mode   <= 1'b0;
      decim_ratio <= sad_pkg::CFG_DATA_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        sad_pkg::REG_ACTIVE:      active      <= cfg_data[0];
        sad_pkg::REG_MONO_MODE:   mono_mode   <= cfg_data[0];
        sad_pkg::REG_DECIM_RATIO: decim_ratio <= cfg_data;
        default: ;
      endcase
    end
  end

  // A ratio of zero acts as one; ratios above the maximum saturate.
  always_comb begin
    if (decim_ratio == '0) begin
      ratio_eff = RATIO_W'(1);
    end else if (int'(decim_ratio) > MAX_RATIO) begin
      ratio_eff = RATIO_W'(MAX_RATIO);
    end else begin
      ratio_eff = RATIO_W'(decim_ratio);
    end
  end

  assign frame_ready = !job_full;
  assign accept      = frame_valid && frame_ready;

  assign left_sum_next  = left_sum +
                          {{(SUM_W-sad_pkg::SAMPLE_W){left_in[sad_pkg::SAMPLE_W-1]}}, left_in};
  assign right_sum_next = right_sum +
                          {{(SUM_W-sad_pkg::SAMPLE_W){right_in[sad_pkg::SAMPLE_W-1]}}, right_in};
  assign frames_gathered_next = frames_gathered + RATIO_W'(1);
  assign run_done = frames_gathered_next >= ratio_eff;

  assign job_push = accept && active && run_done;
  assign job_data = {batch_end_in, mono_mode, ratio_eff, right_sum_next, left_sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum        <= '0;
      right_sum       <= '0;
      frames_gathered <= '0;
    end else if (accept && active) begin
      if (run_done) begin
        left_sum        <= '0;
        right_sum       <= '0;
        frames_gathered <= '0;
      end else begin
        left_sum        <= left_sum_next;
        right_sum       <= right_sum_next;
        frames_gathered <= frames_gathered_next;
      end
    end
  end

  // The count is cleared as soon as it reaches the ratio, which never exceeds the maximum.
  a_gathered_bound: assert property (@(posedge clk) disable iff (rst)
    int'(frames_gathered) < MAX_RATIO)
    else $error("frame count reached the maximum ratio without completing a run");

endmodule

// ===== rtl/sad_fifo.sv =====
// Small register queue between the front and back parts.
`timescale 1ns / 1ps

module sad_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sad_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");

endmodule

// ===== rtl/sad_back.sv =====
// Back part: shared restoring divider and output register for averaged samples.
`timescale 1ns / 1ps

module sad_back #(
  parameter int MAX_RATIO = sad_pkg::MAX_RATIO_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  input  logic [sad_pkg::job_w(MAX_RATIO)-1:0] job_data,
  output logic                                job_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sad_pkg::SAMPLE_W-1:0]        sample_out,
  output logic                                last_of_run,
  output logic                                batch_end_out
);

  localparam int SUM_W   = sad_pkg::sum_w(MAX_RATIO);
  localparam int RATIO_W = sad_pkg::ratio_w(MAX_RATIO);
  localparam int JOB_W   = sad_pkg::job_w(MAX_RATIO);
  localparam int DIV_W   = SUM_W + 1;
  localparam int STEP_W  = $clog2(DIV_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]               state;
  logic                     phase;
  logic [STEP_W-1:0]        step;
  logic [DIV_W-1:0]         acc;
  logic [RATIO_W-1:0]       rem;
  logic                     neg;

  logic signed [SUM_W-1:0]  job_left;
  logic signed [SUM_W-1:0]  job_right;
  logic [RATIO_W-1:0]       job_ratio;
  logic                     job_mono;
  logic                     job_bend;

  logic                     load_right;
  logic signed [DIV_W-1:0]  dividend;
  logic [DIV_W-1:0]         magnitude;
  logic [RATIO_W:0]         trial;
  logic                     fits;
  logic [RATIO_W-1:0]       rem_next;
  logic [DIV_W-1:0]         quot;
  logic [DIV_W-1:0]         quot_round;
  logic [DIV_W-1:0]         result;
  logic                     last_part;

  assign job_left  = job_data[SUM_W-1:0];
  assign job_right = job_data[2*SUM_W-1:SUM_W];
  assign job_ratio = job_data[2*SUM_W+RATIO_W-1:2*SUM_W];
  assign job_mono  = job_data[JOB_W-2];
  assign job_bend  = job_data[JOB_W-1];

  // The right channel is loaded when leaving the output state after the left sample.
  assign load_right = state == ST_OUT;

  always_comb begin
    if (job_mono) begin
      dividend = DIV_W'(job_left) + DIV_W'(job_right);
    end else if (load_right) begin
      dividend = DIV_W'(job_right);
    end else begin
      dividend = DIV_W'(job_left);
    end
    magnitude = dividend[DIV_W-1] ? DIV_W'(0) - dividend : dividend;
  end

  // One quotient bit per cycle, most significant first.
  assign trial    = {rem, acc[DIV_W-1]};
  assign fits     = trial >= {1'b0, job_ratio};
  assign rem_next = fits ? RATIO_W'(trial - {1'b0, job_ratio}) : trial[RATIO_W-1:0];

  // Restore the sign, then halve toward zero for the mono mix.
  always_comb begin
    quot       = neg ? DIV_W'(0) - acc : acc;
    quot_round = quot + DIV_W'(quot[DIV_W-1]);
    result     = job_mono ? {quot_round[DIV_W-1], quot_round[DIV_W-1:1]} : quot;
  end

  assign last_part = job_mono || phase;
  assign job_pop   = (state == ST_OUT) && out_ready && last_part;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            neg   <= dividend[DIV_W-1];
            acc   <= magnitude;
            rem   <= '0;
            step  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          acc  <= {acc[DIV_W-2:0], fits};
          rem  <= rem_next;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_W - 1)) begin
            state <= ST_RES;
          end
        end
        ST_RES: begin
          sample_out    <= result[sad_pkg::SAMPLE_W-1:0];
          last_of_run   <= last_part;
          batch_end_out <= last_part && job_bend;
          out_valid     <= 1'b1;
          state         <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_part) begin
              phase <= 1'b0;
              state <= ST_IDLE;
            end else begin
              phase <= 1'b1;
              neg   <= dividend[DIV_W-1];
              acc   <= magnitude;
              rem   <= '0;
              step  <= '0;
              state <= ST_DIV;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_job_held: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> job_valid)
    else $error("back part working without a queued run");

  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid == (state == ST_OUT))
    else $error("output valid out of step with the sequencer");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the stereo average decimator.
`timescale 1ns / 1ps

// Frame requests go in on s_axis and averaged sample requests come out on m_axis.
// Each accepted frame is fed to a behavioral model of the averaging. That model keeps
// its own running sums, frame count and register copies, and queues the samples the
// block should produce. A checker takes every accepted sample and compares it field by
// field with the oldest queued one.
// The run starts with a few directed frames that cover:
//   - the extremes,
//   - mono and stereo output,
//   - ratio zero and saturated ratios,
//   - a ratio lowered mid-run,
//   - frames dropped while inactive,
//   - a write to an unused register index.
// After that come random phases with random register settings.
module testbench;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 6;
  // A stereo run needs two divider passes. This settle time covers one whole run
  // plus margin.
  localparam int SETTLE_CYCLES = 80;
  localparam int ITEM_TARGET   = 1550;
  localparam int RATIO_CEILING = sad_pkg::MAX_RATIO_DEFAULT;
  localparam longint RUN_LIMIT_NS = 20_000_000;

  // Index 3 has no register behind it, so a write to it must be ignored.
  localparam logic [sad_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_LONG_STALLS} rx_mode_t;

  // One output sample as the block should produce it.
  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    logic        batch_end;
  } out_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [31:0]                     s_axis_tdata  = '0;  // left_in, right_in
  logic                            s_axis_tlast  = 1'b0; // batch_end_in
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [15:0]                     m_axis_tdata;   // sample_out
  logic                            m_axis_tlast;   // last_of_run
  logic                            m_axis_tuser;   // batch_end_out
  logic                            cfg_valid     = 1'b0;
  logic                            cfg_ready;
  logic [sad_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [sad_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

  // The model's copy of the registers and the running state, at their reset values.
  logic       avg_active = 1'b0;
  logic       avg_mono   = 1'b0;
  logic [4:0] avg_ratio  = 5'd1;
  int         left_acc    = 0;
  int         right_acc   = 0;
  int         frames_held = 0;

  out_sample_t expected_samples[$];

  // Traffic shaping.
  bit       sender_bursty = 1'b1;
  int       tx_burst_left = 0;
  rx_mode_t rx_mode       = RX_ALWAYS;
  int       rx_hold       = 0;
  bit       rx_level      = 1'b0;

  // Run statistics.
  int errors          = 0;
  int frames_sent     = 0;
  int active_frames   = 0;
  int samples_checked = 0;
  int mono_samples    = 0;
  int writes_done     = 0;

  always #CLK_HALF clk = ~clk;

  stereo_average_decimator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Boxcar model. A frame is added to the sums while the block is active. A frame that
  // fills the run queues the averages and clears the sums. The ratio is clamped to
  // 1..RATIO_CEILING. A count already past a newly lowered ratio completes on the next
  // frame. SystemVerilog integer division truncates toward zero, which matches the
  // block.
  task automatic average_frame(input logic signed [15:0] left, input logic signed [15:0] right,
                               input logic bend);
    int divisor;
    int mixed;
    int left_avg;
    int right_avg;
    if (!avg_active) return;
    divisor = (avg_ratio == 0) ? 1 : ((avg_ratio > RATIO_CEILING) ? RATIO_CEILING : avg_ratio);
    left_acc += left;
    right_acc += right;
    frames_held++;
    if (frames_held < divisor) return;
    if (avg_mono) begin
      mixed = ((left_acc + right_acc) / divisor) / 2;
      expected_samples.push_back(out_sample_t'{mixed[15:0], 1'b1, bend});
    end else begin
      left_avg = left_acc / divisor;
      right_avg = right_acc / divisor;
      expected_samples.push_back(out_sample_t'{left_avg[15:0], 1'b0, 1'b0});
      expected_samples.push_back(out_sample_t'{right_avg[15:0], 1'b1, bend});
    end
    left_acc = 0;
    right_acc = 0;
    frames_held = 0;
  endtask

  // Sample checker. It runs at every rising edge outside reset and compares each
  // accepted sample with the oldest expectation.
  always @(posedge clk) begin
    out_sample_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      samples_checked++;
      if (expected_samples.size() == 0) begin
        $error("sample_out: no sample expected, got %0d", $signed(m_axis_tdata));
        errors++;
      end else begin
        want = expected_samples.pop_front();
        if (m_axis_tdata !== want.sample) begin
          $error("sample_out: expected %0d, got %0d", $signed(want.sample), $signed(m_axis_tdata));
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser !== want.batch_end) begin
          $error("batch_end_out: expected %0b, got %0b", want.batch_end, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure. In one mode it is always ready. In another it flips a
  // coin each cycle. In the third it toggles between long ready and long stalled
  // stretches.
  always @(negedge clk) begin
    case (rx_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(1, 40);
          rx_level = ~rx_level;
        end
        rx_hold--;
        m_axis_tready <= rx_level;
      end
    endcase
  end

  // Sends one frame request and waits for it to be accepted. When the sender is bursty,
  // a random gap is usually inserted before a new burst starts. Valid stays high between
  // back-to-back frames.
  task automatic send_frame(input logic signed [15:0] left, input logic signed [15:0] right,
                            input logic bend);
    int gap;
    gap = 0;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 20);
      if (sender_bursty && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    tx_burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    s_axis_tlast  <= bend;
    do @(posedge clk); while (!s_axis_tready);
    frames_sent++;
    if (avg_active) active_frames++;
    average_frame(left, right, bend);
  endtask

  // Stops the sender and waits until every expected sample has arrived. It then lets
  // the divider settle, because a frame that completes no run may still be in flight.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write. It is only issued once the block has gone idle.
  task automatic cfg_write(input logic [sad_pkg::CFG_INDEX_W-1:0] index,
                           input logic [sad_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      sad_pkg::REG_ACTIVE:      avg_active = data[0];
      sad_pkg::REG_MONO_MODE:   avg_mono = data[0];
      sad_pkg::REG_DECIM_RATIO: avg_ratio = data;
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random sample. Full-scale values and values near zero are weighted up.
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Out of reset the block is inactive, so these frames must vanish. Then, at the
  // reset ratio of 1, stereo frames pass straight through.
  task automatic test_inactive_after_reset();
    send_frame(16'sh1234, -16'sh1234, 1'b1);
    cfg_write(sad_pkg::REG_ACTIVE, 5'd1);
    send_frame(16'sh7fff, 16'sh8000, 1'b1);
    send_frame(16'sh8000, 16'sh7fff, 1'b0);
    send_frame(16'sh0000, -16'sh0001, 1'b1);
  endtask

  // Mono at ratio 1 is a plain downmix. The halving must truncate toward zero for
  // small negative sums.
  task automatic test_mono_downmix();
    cfg_write(sad_pkg::REG_MONO_MODE, 5'd1);
    send_frame(16'sh7fff, 16'sh7fff, 1'b1);
    send_frame(16'sh8000, 16'sh8000, 1'b0);
    send_frame(-16'sh0003, 16'sh0000, 1'b1);
  endtask

  // A ratio of zero behaves as a ratio of one.
  task automatic test_ratio_zero();
    cfg_write(sad_pkg::REG_MONO_MODE, 5'd0);
    cfg_write(sad_pkg::REG_DECIM_RATIO, 5'd0);
    send_frame(16'sh3039, -16'sh3039, 1'b1);
  endtask

  // Ratio 31 saturates to 16. A full run of full-scale frames checks the sum width.
  // The run is split by an inactive stretch, during which a frame is dropped, and by a
  // write to the unused index. Neither may disturb the held sums.
  task automatic test_ratio_saturation();
    cfg_write(sad_pkg::REG_DECIM_RATIO, 5'd31);
    for (int i = 0; i < 8; i++) send_frame(16'sh8000, 16'sh7fff, 1'b0);
    cfg_write(sad_pkg::REG_ACTIVE, 5'd0);
    send_frame(16'sh7fff, 16'sh8000, 1'b1);
    cfg_write(REG_UNUSED, 5'h1f);
    cfg_write(sad_pkg::REG_ACTIVE, 5'd1);
    for (int i = 0; i < 8; i++) send_frame(16'sh8000, 16'sh7fff, i == 7);
  endtask

  // Three frames go into a run of four. The ratio then drops to two, so the next frame
  // completes the run, and all four frames are divided by two.
  task automatic test_ratio_lowered();
    cfg_write(sad_pkg::REG_DECIM_RATIO, 5'd4);
    send_frame(16'sd1000, -16'sd1000, 1'b1);
    send_frame(16'sd2000, -16'sd7, 1'b0);
    send_frame(16'sd3, 16'sd3, 1'b0);
    cfg_write(sad_pkg::REG_DECIM_RATIO, 5'd2);
    send_frame(-16'sd1, 16'sd4, 1'b1);
  endtask

  // Random phases. Each phase picks its own traffic shape and a random subset of
  // register updates, then streams random frames. Ratio changes land on partial runs
  // because writes never clear the sums. Once, midway, the sender holds off until
  // every pending sample has drained.
  task automatic test_random_traffic();
    int phase_items;
    bit drained_midway;
    logic [4:0] ratio_pick;
    drained_midway = 1'b0;
    while (active_frames < ITEM_TARGET) begin
      sender_bursty = ($urandom_range(0, 3) != 0);
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      if ($urandom_range(0, 1)) cfg_write(sad_pkg::REG_MONO_MODE, 5'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       ratio_pick = 5'd0;
          1:       ratio_pick = 5'd16;
          2:       ratio_pick = 5'($urandom_range(17, 31));
          3:       ratio_pick = 5'($urandom_range(5, 15));
          default: ratio_pick = 5'($urandom_range(1, 4));
        endcase
        cfg_write(sad_pkg::REG_DECIM_RATIO, ratio_pick);
      end
      if ($urandom_range(0, 15) == 0) cfg_write(REG_UNUSED, 5'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        cfg_write(sad_pkg::REG_ACTIVE, 5'd0);
        repeat ($urandom_range(1, 6))
          send_frame(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
        cfg_write(sad_pkg::REG_ACTIVE, 5'd1);
      end
      phase_items = $urandom_range(10, 60);
      for (int n = 0; n < phase_items; n++) begin
        send_frame(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
        if (!drained_midway && active_frames > ITEM_TARGET / 2) begin
          wait_idle();
          drained_midway = 1'b1;
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_inactive_after_reset();
    test_mono_downmix();
    test_ratio_zero();
    test_ratio_saturation();
    test_ratio_lowered();
    test_random_traffic();
    wait_idle();
    $display("Run covered %0d frame requests, %0d taken while active, and %0d register writes.",
             frames_sent, active_frames, writes_done);
    $display("It checked %0d output samples across stereo and mono runs at ratios 0 to 31.",
             samples_checked);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog. A hang anywhere in the run ends it as a failure.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d samples still expected.", expected_samples.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
